### rtl/core/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg: shared types and constants of the HTTP header line parser
// Byte codes, the header name to look for, default sizes and the record
// of one ended line.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  // Default sizes handed to the top level
  localparam int unsigned MAX_LINES_DEF    = 32;
  localparam int unsigned COUNT_WIDTH_DEF  = 10;
  localparam int unsigned VALUE_WIDTH_DEF  = 32;

  // Byte codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Header name "Content-Length", padded to a power of two with NUL
  localparam int unsigned KEY_LEN = 14;
  localparam logic [7:0] KEY_TEXT [16] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h00, 8'h00
  };

  // Kind of line end reported
  typedef enum logic [1:0] {
    EV_STATUS    = 2'd0,
    EV_HEADER    = 2'd1,
    EV_BLOCK_END = 2'd2
  } event_kind_e;

  // Progress of the decimal value reader
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } number_phase_e;

  // One input request
  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
  } in_item_t;

  // One ended line
  typedef struct packed {
    event_kind_e event_kind;
    logic        header_overflow;
    logic        length_saturated;
    logic [31:0] content_length;
    logic        is_content_length;
    logic        has_colon;
    logic [9:0]  value_length;
    logic [9:0]  name_length;
    logic [4:0]  line_index;
  } result_t;

endpackage

### rtl/core/hhlp_in_stage.sv
// ----------------------------------------------------------------------------
// hhlp_in_stage: input register
// Captures one byte request and holds it until the line core takes it.
// ----------------------------------------------------------------------------
module hhlp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  hhlp_pkg::in_item_t item_i,
  output logic               valid_o,
  output hhlp_pkg::in_item_t item_o,
  input  logic               advance_i
);

  logic               valid_q;
  hhlp_pkg::in_item_t item_q;

  // Take a new request when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

### rtl/core/hhlp_line_core.sv
// ----------------------------------------------------------------------------
// hhlp_line_core: per-byte line state and line end report
// Tracks CR/LF pairs, name and value lengths, the Content-Length name match
// and its decimal value; emits one record for each ended line.
// ----------------------------------------------------------------------------
module hhlp_line_core #(
  parameter int unsigned MAX_LINES          = hhlp_pkg::MAX_LINES_DEF,
  parameter int unsigned LENGTH_COUNT_WIDTH = hhlp_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH        = hhlp_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  hhlp_pkg::in_item_t item_i,
  output logic               res_valid_o,
  output hhlp_pkg::result_t  res_o
);

  localparam int unsigned CW = LENGTH_COUNT_WIDTH;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned LW = $clog2(MAX_LINES + 1);

  typedef struct packed {
    logic                    colon;
    logic [CW-1:0]           name_cnt;
    logic [CW-1:0]           value_cnt;
    logic [3:0]              match_pos;
    logic                    match_ok;
    hhlp_pkg::number_phase_e phase;
    logic [VW-1:0]           acc;
    logic                    acc_sat;
  } line_t;

  function automatic line_t clear_line();
    line_t r;
    r.colon     = 1'b0;
    r.name_cnt  = '0;
    r.value_cnt = '0;
    r.match_pos = '0;
    r.match_ok  = 1'b1;
    r.phase     = hhlp_pkg::PH_SKIP;
    r.acc       = '0;
    r.acc_sat   = 1'b0;
    return r;
  endfunction

  function automatic logic [9:0] clip_count(logic [CW-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return (w > 16'd1023) ? 10'd1023 : w[9:0];
  endfunction

  // Fold one line byte into the line state
  function automatic line_t add_byte(line_t s, logic [7:0] c);
    line_t                   r;
    logic                    digit;
    hhlp_pkg::number_phase_e ph;
    logic [VW+3:0]           prod;
    r     = s;
    digit = (c >= hhlp_pkg::CH_ZERO) && (c <= hhlp_pkg::CH_NINE);
    ph    = s.phase;
    prod  = '0;
    if (!s.colon) begin
      if (c == hhlp_pkg::CH_COLON) begin
        r.colon = 1'b1;
      end else begin
        if (s.name_cnt != '1) begin
          r.name_cnt = s.name_cnt + 1'b1;
        end
        if (s.match_ok && (s.match_pos < 4'(hhlp_pkg::KEY_LEN)) &&
            (c == hhlp_pkg::KEY_TEXT[s.match_pos])) begin
          r.match_pos = s.match_pos + 1'b1;
        end else begin
          r.match_ok = 1'b0;
        end
      end
    end else begin
      if (s.value_cnt != '1) begin
        r.value_cnt = s.value_cnt + 1'b1;
      end
      // Skip leading blanks, then read digits until the first non-digit
      if (!((s.phase == hhlp_pkg::PH_SKIP) &&
            ((c == hhlp_pkg::CH_SPACE) || (c == hhlp_pkg::CH_TAB)))) begin
        if (s.phase == hhlp_pkg::PH_SKIP) begin
          ph = digit ? hhlp_pkg::PH_DIGITS : hhlp_pkg::PH_STOP;
        end else if ((s.phase == hhlp_pkg::PH_DIGITS) && !digit) begin
          ph = hhlp_pkg::PH_STOP;
        end
        r.phase = ph;
        if (ph == hhlp_pkg::PH_DIGITS) begin
          prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (VW+4)'(c[3:0]);
          if (s.acc_sat || (prod[VW+3:VW] != 4'b0)) begin
            r.acc     = '1;
            r.acc_sat = 1'b1;
          end else begin
            r.acc = prod[VW-1:0];
          end
        end
      end
    end
    return r;
  endfunction

  line_t         line_q, line_d;
  logic          prev_cr_q, prev_cr_d;
  logic          done_q, done_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] latest_q, latest_d;
  logic          lsat_q, lsat_d;
  logic          emit;
  logic          empty;
  logic          is_cl;
  logic          overflow;
  logic [LW-1:0] idx;
  hhlp_pkg::result_t res_d;

  // Next state and line end report for the held byte
  always_comb begin
    if (item_i.first_byte) begin
      line_d    = clear_line();
      prev_cr_d = 1'b0;
      done_d    = 1'b0;
      cnt_d     = '0;
      latest_d  = '0;
      lsat_d    = 1'b0;
    end else begin
      line_d    = line_q;
      prev_cr_d = prev_cr_q;
      done_d    = done_q;
      cnt_d     = cnt_q;
      latest_d  = latest_q;
      lsat_d    = lsat_q;
    end
    emit     = 1'b0;
    empty    = 1'b0;
    is_cl    = 1'b0;
    overflow = 1'b0;
    idx      = '0;
    res_d    = '0;
    if (!done_d) begin
      if (prev_cr_d && (item_i.data_byte == hhlp_pkg::CH_LF)) begin
        // End the line
        prev_cr_d = 1'b0;
        emit      = 1'b1;
        empty     = (line_d.name_cnt == '0) && !line_d.colon;
        is_cl     = !empty && (cnt_d != '0) && line_d.colon && line_d.match_ok &&
                    (line_d.match_pos == 4'(hhlp_pkg::KEY_LEN));
        overflow  = (cnt_d == LW'(MAX_LINES));
        idx       = overflow ? LW'(MAX_LINES - 1) : cnt_d;
        if (is_cl) begin
          latest_d = line_d.acc;
          lsat_d   = line_d.acc_sat;
        end
        if (empty) begin
          res_d.event_kind = hhlp_pkg::EV_BLOCK_END;
        end else if (cnt_d == '0) begin
          res_d.event_kind = hhlp_pkg::EV_STATUS;
        end else begin
          res_d.event_kind = hhlp_pkg::EV_HEADER;
        end
        res_d.line_index        = 5'(idx);
        res_d.name_length       = clip_count(line_d.name_cnt);
        res_d.value_length      = clip_count(line_d.value_cnt);
        res_d.has_colon         = line_d.colon;
        res_d.is_content_length = is_cl;
        res_d.content_length    = 32'(latest_d);
        res_d.length_saturated  = lsat_d;
        res_d.header_overflow   = overflow;
        if (empty) begin
          done_d = 1'b1;
        end
        if (!overflow) begin
          cnt_d = cnt_d + 1'b1;
        end
        line_d = clear_line();
      end else begin
        // A pending lone CR becomes a line byte
        if (prev_cr_d) begin
          line_d = add_byte(line_d, hhlp_pkg::CH_CR);
        end
        if (item_i.data_byte == hhlp_pkg::CH_CR) begin
          prev_cr_d = 1'b1;
        end else begin
          prev_cr_d = 1'b0;
          line_d    = add_byte(line_d, item_i.data_byte);
        end
      end
    end
  end

  assign res_valid_o = advance_i && emit;
  assign res_o       = res_d;

  // Advance state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= clear_line();
      prev_cr_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      latest_q  <= '0;
      lsat_q    <= 1'b0;
    end else if (advance_i) begin
      line_q    <= line_d;
      prev_cr_q <= prev_cr_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
      latest_q  <= latest_d;
      lsat_q    <= lsat_d;
    end
  end

  // An empty line closes the header block
  a_block_end_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.event_kind == hhlp_pkg::EV_BLOCK_END) |=> done_q)
    else $error("header block end did not stop the parser");

  // Nothing is reported after the block end until a restart
  a_quiet_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && done_q && !item_i.first_byte |-> !res_valid_o)
    else $error("line reported after header block end");

  // A reported line leaves a fresh line state behind
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (line_q.name_cnt == '0) && !line_q.colon && !prev_cr_q)
    else $error("line state not cleared after line end");

endmodule

### rtl/core/hhlp_out_queue.sv
// ----------------------------------------------------------------------------
// hhlp_out_queue: two-entry result queue
// Holds ended-line records so the core keeps running while the consumer
// stalls, as long as an entry is free.
// ----------------------------------------------------------------------------
module hhlp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hhlp_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hhlp_pkg::result_t data_o
);

  hhlp_pkg::result_t mem_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("result queue fill level out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("record pushed into full result queue");

endmodule

### rtl/core/http_header_line_parser.sv
// ----------------------------------------------------------------------------
// http_header_line_parser: HTTP response header line parser
// Splits a byte stream into CR/LF-terminated lines and reports one record
// per line: kind, index, name and value lengths, colon and Content-Length.
//
//   Channel   Dir  Beat                 Payload
//   s_axis    in   one response byte    tdata: data_byte; tuser: first_byte
//   m_axis    out  one ended line       tdata: line fields; tuser: event_kind
//
// One byte is taken every cycle while the result queue has room; the
// per-byte update is a single pass of compares, counter increments and
// one multiply-by-ten add. A line's LF byte is held in the input register,
// and its record is written into the result queue once the queue has room.
// Reset clears all parser state at once; there is no clearing pass.
// A two-entry result queue absorbs output stalls; the input stalls only
// while that queue is full.
// ----------------------------------------------------------------------------
module http_header_line_parser #(
  parameter int unsigned MAX_LINES          = hhlp_pkg::MAX_LINES_DEF,
  parameter int unsigned LENGTH_COUNT_WIDTH = hhlp_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH        = hhlp_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte
  input  logic [7:0]  s_axis_tdata,
  // [0] first_byte
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] line_index, [14:5] name_length, [24:15] value_length,
  // [25] has_colon, [26] is_content_length, [58:27] content_length,
  // [59] length_saturated, [60] header_overflow, [63:61] zero
  output logic [63:0] m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]  m_axis_tuser
);

  hhlp_pkg::in_item_t in_item;
  hhlp_pkg::in_item_t held_item;
  logic               held_valid;
  logic               advance;
  logic               res_valid;
  hhlp_pkg::result_t  res;
  hhlp_pkg::result_t  out_res;
  logic               queue_full;

  assign in_item.data_byte  = s_axis_tdata;
  assign in_item.first_byte = s_axis_tuser[0];

  // Process the held byte while the queue has room
  assign advance = held_valid && !queue_full;

  hhlp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .item_o    (held_item),
    .advance_i (advance)
  );

  hhlp_line_core #(
    .MAX_LINES          (MAX_LINES),
    .LENGTH_COUNT_WIDTH (LENGTH_COUNT_WIDTH),
    .VALUE_WIDTH        (VALUE_WIDTH)
  ) u_line_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hhlp_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (queue_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  // Pack the record onto the stream
  assign m_axis_tdata = {3'b000,
                         out_res.header_overflow,
                         out_res.length_saturated,
                         out_res.content_length,
                         out_res.is_content_length,
                         out_res.has_colon,
                         out_res.value_length,
                         out_res.name_length,
                         out_res.line_index};
  assign m_axis_tuser = out_res.event_kind;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for http_header_line_parser
// Streams HTTP responses byte by byte into the parser and checks every line
// record against a line-by-line model of the parser kept in this bench.
// Covers edge cases by hand, long and overflowing headers, output back
// pressure and random responses under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CNT_MAX     = (1 << hhlp_pkg::COUNT_WIDTH_DEF) - 1;
  localparam logic [63:0] LEN_MAX     = 64'hFFFF_FFFF;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] data_byte
  logic [7:0]  s_axis_tdata  = '0;
  // [0] first_byte
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [4:0] line_index, [14:5] name_length, [24:15] value_length,
  // [25] has_colon, [26] is_content_length, [58:27] content_length,
  // [59] length_saturated, [60] header_overflow
  logic [63:0] m_axis_tdata;
  // [1:0] event_kind
  logic [1:0]  m_axis_tuser;

  http_header_line_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Line records still owed by the parser, oldest first
  hhlp_pkg::result_t line_q[$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;
  bit          resp_first;

  int unsigned err_cnt     = 0;
  int unsigned n_bytes     = 0;
  int unsigned n_lines     = 0;
  int unsigned n_block_end = 0;
  int unsigned n_cl_lines  = 0;
  int unsigned n_len_sat   = 0;
  int unsigned n_overflow  = 0;
  int unsigned quiet_cycles = 0;
  hhlp_pkg::result_t seen_rec;
  hhlp_pkg::result_t want_rec;

  // Parser state as the bench tracks it
  bit                      pend_cr;
  bit                      block_done;
  int unsigned             line_cnt;
  bit                      colon_hit;
  int unsigned             name_cnt;
  int unsigned             val_cnt;
  int unsigned             key_pos;
  bit                      key_ok;
  hhlp_pkg::number_phase_e num_ph;
  logic [63:0]             num_acc;
  bit                      num_sat;
  logic [31:0]             last_len;
  bit                      last_sat;

  // ------------------------------------------------------------------------
  // Line model
  // ------------------------------------------------------------------------
  function void clear_line_state();
    colon_hit = 1'b0;
    name_cnt  = 0;
    val_cnt   = 0;
    key_pos   = 0;
    key_ok    = 1'b1;
    num_ph    = hhlp_pkg::PH_SKIP;
    num_acc   = '0;
    num_sat   = 1'b0;
  endfunction

  function void restart_parser();
    pend_cr    = 1'b0;
    block_done = 1'b0;
    line_cnt   = 0;
    last_len   = '0;
    last_sat   = 1'b0;
    clear_line_state();
  endfunction

  // Accumulate the decimal value of a header line
  function void digit_step(logic [7:0] c);
    bit          is_dig;
    logic [63:0] d;
    is_dig = (c >= hhlp_pkg::CH_ZERO) && (c <= hhlp_pkg::CH_NINE);
    if (num_ph == hhlp_pkg::PH_SKIP) begin
      if (c == hhlp_pkg::CH_SPACE || c == hhlp_pkg::CH_TAB) return;
      num_ph = is_dig ? hhlp_pkg::PH_DIGITS : hhlp_pkg::PH_STOP;
    end else if (num_ph == hhlp_pkg::PH_DIGITS && !is_dig) begin
      num_ph = hhlp_pkg::PH_STOP;
    end
    if (num_ph == hhlp_pkg::PH_DIGITS) begin
      d = 64'(c - hhlp_pkg::CH_ZERO);
      if (num_sat || num_acc > (LEN_MAX - d) / 10) begin
        num_acc = LEN_MAX;
        num_sat = 1'b1;
      end else begin
        num_acc = num_acc * 10 + d;
      end
    end
  endfunction

  // Count one byte into the name or the value of the current line
  function void line_byte(logic [7:0] c);
    if (!colon_hit) begin
      if (c == hhlp_pkg::CH_COLON) begin
        colon_hit = 1'b1;
        return;
      end
      if (name_cnt < CNT_MAX) name_cnt++;
      if (key_ok && key_pos < hhlp_pkg::KEY_LEN && c == hhlp_pkg::KEY_TEXT[key_pos])
        key_pos++;
      else key_ok = 1'b0;
    end else begin
      if (val_cnt < CNT_MAX) val_cnt++;
      digit_step(c);
    end
  endfunction

  // Build the record of the line that just ended
  function void finish_line(output hhlp_pkg::result_t r);
    bit blank_line;
    bit is_cl;
    bit ovf;
    blank_line = (name_cnt == 0) && !colon_hit;
    is_cl = !blank_line && line_cnt != 0 && colon_hit && key_ok &&
            key_pos == hhlp_pkg::KEY_LEN;
    ovf   = line_cnt >= hhlp_pkg::MAX_LINES_DEF;
    if (is_cl) begin
      last_len = num_acc[31:0];
      last_sat = num_sat;
    end
    r.event_kind        = blank_line ? hhlp_pkg::EV_BLOCK_END :
                          (line_cnt == 0 ? hhlp_pkg::EV_STATUS : hhlp_pkg::EV_HEADER);
    r.line_index        = ovf ? 5'(hhlp_pkg::MAX_LINES_DEF - 1) : 5'(line_cnt);
    r.name_length       = 10'(name_cnt);
    r.value_length      = 10'(val_cnt);
    r.has_colon         = colon_hit;
    r.is_content_length = is_cl;
    r.content_length    = last_len;
    r.length_saturated  = last_sat;
    r.header_overflow   = ovf;
    if (blank_line) block_done = 1'b1;
    if (line_cnt < hhlp_pkg::MAX_LINES_DEF) line_cnt++;
    clear_line_state();
  endfunction

  // Advance the model by one accepted byte
  function void parse_byte(input bit first, input logic [7:0] b,
                           output bit got, output hhlp_pkg::result_t r);
    got = 1'b0;
    r   = '0;
    if (first) restart_parser();
    if (block_done) return;
    if (pend_cr) begin
      pend_cr = 1'b0;
      if (b == hhlp_pkg::CH_LF) begin
        finish_line(r);
        got = 1'b1;
        return;
      end
      line_byte(hhlp_pkg::CH_CR);
    end
    if (b == hhlp_pkg::CH_CR) begin
      pend_cr = 1'b1;
      return;
    end
    line_byte(b);
  endfunction

  // ------------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------------
  task automatic send_byte(input bit first, input logic [7:0] b);
    bit                got;
    hhlp_pkg::result_t rec;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    n_bytes++;
    parse_byte(first, b, got, rec);
    if (got) line_q.push_back(rec);
  endtask

  // Send one byte of the current response, flagging its opening byte
  task automatic feed(input logic [7:0] b);
    send_byte(resp_first, b);
    resp_first = 1'b0;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  task automatic feed_crlf();
    feed(hhlp_pkg::CH_CR);
    feed(hhlp_pkg::CH_LF);
  endtask

  // Hold the input until every owed record has come out
  task automatic wait_lines_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (line_q.size() != 0);
  endtask

  // Mostly printable text, now and then any byte at all
  function automatic logic [7:0] text_byte();
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  // One header line: exact, near-miss, random or empty name, value with or without digits, or no separator
  task automatic send_header_line();
    int unsigned sel;
    string       nm;
    sel = $urandom_range(9);
    nm  = "Content-Length";
    if (sel == 8) begin
      // line without a separator
      repeat ($urandom_range(12, 1)) feed(text_byte());
      feed_crlf();
      return;
    end
    case (sel)
      4: nm[$urandom_range(13)] = text_byte();
      5: nm = nm.substr(0, $urandom_range(12));
      6: nm = {nm, "s"};
      7, 9: nm = "";
      default: ;
    endcase
    feed_text(nm);
    if (sel == 7) repeat ($urandom_range(10)) feed(text_byte());
    feed(hhlp_pkg::CH_COLON);
    repeat ($urandom_range(3)) feed($urandom_range(1) ? hhlp_pkg::CH_SPACE : hhlp_pkg::CH_TAB);
    if (sel != 9 || $urandom_range(1)) begin
      case ($urandom_range(9))
        0: feed_text("4294967295");
        1: feed_text("4294967296");
        2: repeat ($urandom_range(22, 11)) feed(8'(hhlp_pkg::CH_ZERO + $urandom_range(9)));
        default: repeat ($urandom_range(10)) feed(8'(hhlp_pkg::CH_ZERO + $urandom_range(9)));
      endcase
    end
    if ($urandom_range(1)) repeat ($urandom_range(6, 1)) feed(text_byte());
    feed_crlf();
  endtask

  // One response; a cut one stops inside a line and never ends its block
  task automatic send_response(input bit cut);
    int unsigned k;
    int unsigned nh;
    resp_first = 1'b1;
    k = $urandom_range(19);
    if (k != 0) begin
      if (k < 3) feed_text("Content-Length: 12");
      else repeat ($urandom_range(15, 1)) feed(text_byte());
    end
    feed_crlf();
    nh = $urandom_range(5);
    repeat (nh) send_header_line();
    if (cut) begin
      repeat ($urandom_range(4)) feed(text_byte());
      if ($urandom_range(1)) feed(hhlp_pkg::CH_CR);
      return;
    end
    feed_crlf();
    // body bytes, ignored by the parser
    repeat ($urandom_range(3)) feed(text_byte());
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // empty status line ends the block at index 0, then bytes are ignored
    resp_first = 1'b1;
    feed_crlf();
    feed(8'hFF);
    // colon-only status line
    resp_first = 1'b1;
    feed(hhlp_pkg::CH_COLON);
    feed_crlf();
    // lone CR and bare LF in the name, lone CR in the value, byte extremes
    feed(hhlp_pkg::CH_CR);
    feed(8'h00);
    feed(hhlp_pkg::CH_LF);
    feed(8'hFF);
    feed(hhlp_pkg::CH_COLON);
    feed(hhlp_pkg::CH_CR);
    feed(8'h41);
    feed_crlf();
    // pending CR is dropped by a restart
    feed(hhlp_pkg::CH_CR);
    resp_first = 1'b1;
    feed_crlf();
    wait_lines_done();
  endtask

  task automatic test_long_lines();
    idle_pct  = 0;
    stall_pct = 0;
    resp_first = 1'b1;
    feed_text("HTTP/1.1 200 OK");
    feed_crlf();
    // name count saturates
    repeat (1024) feed(8'h4E);
    feed_text(": 12");
    feed_crlf();
    feed_crlf();
    wait_lines_done();
  endtask

  task automatic test_line_overflow();
    idle_pct  = 0;
    stall_pct = 0;
    resp_first = 1'b1;
    feed_text("H");
    feed_crlf();
    repeat (33) begin
      feed_text(":7");
      feed_crlf();
    end
    // lines past the limit are still parsed
    feed_text("Content-Length: 99");
    feed_crlf();
    feed_crlf();
    wait_lines_done();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    resp_first = 1'b1;
    feed_text("S");
    feed_crlf();
    // receiver holds off while short lines keep arriving
    hold_req = 40;
    repeat (10) begin
      feed(8'h61);
      feed_crlf();
    end
    feed_crlf();
    wait_lines_done();
  endtask

  task automatic test_random_traffic(input int unsigned send_idle,
                                     input int unsigned recv_stall,
                                     input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    target    = n_bytes + n_items;
    while (n_bytes < target) begin
      pick = $urandom_range(19);
      if (pick < 16) begin
        send_response(1'b0);
      end else if (pick < 18) begin
        send_response(1'b1);
      end else begin
        // noise with random restarts and many CR and LF bytes
        repeat ($urandom_range(12, 1)) begin
          pick = $urandom_range(7);
          send_byte(pick == 0, pick == 1 ? hhlp_pkg::CH_CR :
                               pick == 2 ? hhlp_pkg::CH_LF : 8'($urandom_range(255)));
        end
      end
    end
    wait_lines_done();
  endtask

  // ------------------------------------------------------------------------
  // Clock
  // ------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Receiver: random stalls and counted hold-offs
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string fname, input longint unsigned want,
                             input longint unsigned seen);
    if (want != seen) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
    end
  endtask

  // ------------------------------------------------------------------------
  // Result check and watchdog
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("http_header_line_parser verification failed");
        $finish;
      end else if (m_axis_tvalid && m_axis_tready) begin
        seen_rec = hhlp_pkg::result_t'({m_axis_tuser, m_axis_tdata[60:0]});
        if (line_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected line record, actual kind %0d index %0d", $time,
                   seen_rec.event_kind, seen_rec.line_index);
        end else begin
          want_rec = line_q.pop_front();
          n_lines++;
          if (want_rec.event_kind == hhlp_pkg::EV_BLOCK_END) n_block_end++;
          if (want_rec.is_content_length) n_cl_lines++;
          if (want_rec.is_content_length && want_rec.length_saturated) n_len_sat++;
          if (want_rec.header_overflow) n_overflow++;
          check_field("event_kind", want_rec.event_kind, seen_rec.event_kind);
          check_field("line_index", want_rec.line_index, seen_rec.line_index);
          check_field("name_length", want_rec.name_length, seen_rec.name_length);
          check_field("value_length", want_rec.value_length, seen_rec.value_length);
          check_field("has_colon", want_rec.has_colon, seen_rec.has_colon);
          check_field("is_content_length", want_rec.is_content_length,
                      seen_rec.is_content_length);
          check_field("content_length", want_rec.content_length,
                      seen_rec.content_length);
          check_field("length_saturated", want_rec.length_saturated,
                      seen_rec.length_saturated);
          check_field("header_overflow", want_rec.header_overflow,
                      seen_rec.header_overflow);
          check_field("tdata pad", 0, m_axis_tdata[63:61]);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    restart_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_long_lines();
    test_line_overflow();
    test_backpressure();
    test_random_traffic(0, 0, 60);
    test_random_traffic(68, 0, 60);
    test_random_traffic(0, 68, 60);
    test_random_traffic(6, 6, 60);
    // let any stray record show up
    repeat (8) @(posedge clk_i);
    if (line_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d line records never arrived", $time, line_q.size());
    end
    $display("Sent %0d bytes, checked %0d line records (%0d header block ends).",
             n_bytes, n_lines, n_block_end);
    $display("Content-Length lines: %0d, saturated: %0d; overflowed lines: %0d.",
             n_cl_lines, n_len_sat, n_overflow);
    if (err_cnt == 0) begin
      $display("http_header_line_parser verification clean");
    end else begin
      $display("http_header_line_parser verification failed");
    end
    $finish;
  end

endmodule
